@@ sv/yuyv_to_rgb_converter_assert.svh @@
// Assertion macros shared by the YUYV to RGB converter modules.
// Needs nothing else; included by the files that carry assertions.
`ifndef YUYV_TO_RGB_CONVERTER_ASSERT_SVH
`define YUYV_TO_RGB_CONVERTER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define YCV_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ycv: assertion failed");

// Next-cycle implication, checked outside reset.
`define YCV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ycv: assertion failed");

`endif

@@ sv/ycv_pkg.sv @@
// Shared types and constants of the YUYV to RGB converter.
// Used by the front, queue, back and top-level modules; depends on nothing.
package ycv_pkg;

	// Queue between front and back: depth is a power of two.
	localparam int unsigned QPTR_W = 1;
	localparam int unsigned QDEPTH = 1 << QPTR_W;
	localparam int unsigned QCNT_W = QPTR_W + 1;

	// Chroma products fit 17 signed bits; luma plus product fits 18.
	localparam int unsigned TERM_W = 17;
	localparam int unsigned SUM_W  = 18;

	localparam logic signed [8:0]        CHROMA_OFS = 9'sd128;
	localparam logic signed [TERM_W-1:0] K_RV = 17'sd359;
	localparam logic signed [TERM_W-1:0] K_GU = 17'sd88;
	localparam logic signed [TERM_W-1:0] K_GV = 17'sd183;
	localparam logic signed [TERM_W-1:0] K_BU = 17'sd454;
	localparam logic [7:0]               PIX_MAX = 8'd255;

	// Register index of the mode bit.
	localparam logic REG_GREY_MODE = 1'b0;

	// Pixel index of the final pixel in each mode.
	localparam logic [1:0] LAST_IDX_COLOUR = 2'd1;
	localparam logic [1:0] LAST_IDX_GREY   = 2'd3;

	typedef struct packed {
		logic                     grey;
		logic                     fend;
		logic [3:0][7:0]          pix;
		logic signed [TERM_W-1:0] r_term;
		logic signed [TERM_W-1:0] g_term;
		logic signed [TERM_W-1:0] b_term;
	} ycv_entry_t;

endpackage

@@ sv/yuyv_to_rgb_converter.sv @@
// YUYV 4:2:2 or 8-bit grey to RGB888 converter, BT.601 fixed point.
// Input beats carry four camera bytes in tdata and the frame-end flag in tlast.
// In colour mode (grey_mode = 0) the bytes are Y0 U Y1 V and each beat yields
// two RGB pixel beats sharing one chroma pair; in grey mode each byte becomes
// one pixel with R = G = B, so a beat yields four pixel beats.
// Output tuser marks the final pixel of each input beat, tlast the final
// pixel of an input beat that carried tlast.
// The mode register sits at APB address 0; it must be written only while idle,
// which the block itself does not enforce. A beat passes through the front
// input register, the queue, the current-item register and the output register
// before its first pixel shows. The output register issues one pixel per cycle
// while the receiver is ready; the front takes a beat per cycle while the
// two-entry queue has room.
// When the receiver stalls, the output beat holds, the queue fills and then
// s_axis_tready falls. Reset clears all valid flags and sets colour mode.
module yuyv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // byte0, byte1, byte2, byte3
	input  logic        s_axis_tlast,  // frame_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red, green, blue
	output logic        m_axis_tuser,  // last_of_item
	output logic        m_axis_tlast   // last_of_frame
);
	import ycv_pkg::*;

	logic       grey_q;
	logic       cfg_wr;
	logic       push;
	logic       pop;
	logic       full;
	logic       head_valid;
	ycv_entry_t push_entry;
	ycv_entry_t head;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grey_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_GREY_MODE) begin
			grey_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_GREY_MODE) ? {31'd0, grey_q} : 32'd0;

	ycv_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.grey_mode     (grey_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.full          (full),
		.push          (push),
		.push_entry    (push_entry)
	);

	ycv_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	ycv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

@@ sv/ycv_front.sv @@
// Input side: registers each accepted beat and computes the chroma terms.
// Depends on ycv_pkg; feeds ycv_fifo.
module ycv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                grey_mode,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [31:0]         s_axis_tdata,  // byte0, byte1, byte2, byte3
	input  logic                s_axis_tlast,  // frame_end
	input  logic                full,
	output logic                push,
	output ycv_pkg::ycv_entry_t push_entry
);
	import ycv_pkg::*;

	logic        valid_s1;
	logic [31:0] data_s1;
	logic        fend_s1;
	logic        grey_s1;
	logic        take;
	logic signed [8:0] u;
	logic signed [8:0] v;

	assign push          = valid_s1 && !full;
	assign s_axis_tready = !valid_s1 || !full;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= s_axis_tdata;
			fend_s1 <= s_axis_tlast;
			grey_s1 <= grey_mode;
		end
	end

	assign u = $signed({1'b0, data_s1[15:8]}) - CHROMA_OFS;
	assign v = $signed({1'b0, data_s1[31:24]}) - CHROMA_OFS;

	always_comb begin
		push_entry.grey   = grey_s1;
		push_entry.fend   = fend_s1;
		push_entry.pix    = data_s1;
		push_entry.r_term = K_RV * TERM_W'(v);
		push_entry.g_term = -(K_GU * TERM_W'(u)) - K_GV * TERM_W'(v);
		push_entry.b_term = K_BU * TERM_W'(u);
	end

endmodule

@@ sv/ycv_fifo.sv @@
// Short queue that decouples the front from the pixel back end.
// Depends on ycv_pkg and the assertion macro header.
`include "yuyv_to_rgb_converter_assert.svh"
module ycv_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ycv_pkg::ycv_entry_t push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ycv_pkg::ycv_entry_t head
);
	import ycv_pkg::*;

	ycv_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	`YCV_ASSERT_IMPL(a_pop_not_empty, clk, arst_n, pop, count_q != '0)
	`YCV_ASSERT_IMPL(a_push_not_full, clk, arst_n, push, count_q != QCNT_W'(QDEPTH))
	`YCV_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

@@ sv/ycv_back.sv @@
// Back end: takes queued items and emits one RGB pixel beat per cycle while
// the receiver is ready. Depends on ycv_pkg and the assertion macro header.
`include "yuyv_to_rgb_converter_assert.svh"
module ycv_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  ycv_pkg::ycv_entry_t head,
	output logic                pop,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [23:0]         m_axis_tdata,  // red, green, blue
	output logic                m_axis_tuser,  // last_of_item
	output logic                m_axis_tlast   // last_of_frame
);
	import ycv_pkg::*;

	ycv_entry_t cur_q;
	logic       cur_valid_q;
	logic [1:0] idx_q;
	logic       m_valid_q;
	logic [23:0] m_data_q;
	logic       m_user_q;
	logic       m_last_q;

	logic       out_free;
	logic       emit;
	logic       last_pix;
	logic       done;
	logic [7:0] y;
	logic signed [SUM_W-1:0] y_ext;
	logic [7:0] r_pix;
	logic [7:0] g_pix;
	logic [7:0] b_pix;
	logic [23:0] pix_data;

	// A negative sum clamps to zero, a quotient of 256 or more to full scale.
	function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] sum);
		logic [7:0] res;
		if (sum[SUM_W-1]) begin
			res = 8'd0;
		end else if (sum[SUM_W-2:16] != '0) begin
			res = PIX_MAX;
		end else begin
			res = sum[15:8];
		end
		return res;
	endfunction

	assign out_free = !m_valid_q || m_axis_tready;
	assign emit     = cur_valid_q && out_free;
	assign last_pix = cur_q.grey ? (idx_q == LAST_IDX_GREY) : (idx_q == LAST_IDX_COLOUR);
	assign done     = emit && last_pix;
	assign pop      = head_valid && (!cur_valid_q || done);

	assign y     = idx_q[0] ? cur_q.pix[2] : cur_q.pix[0];
	assign y_ext = $signed({2'b00, y, 8'h00});
	assign r_pix = clamp_shift(y_ext + SUM_W'(cur_q.r_term));
	assign g_pix = clamp_shift(y_ext + SUM_W'(cur_q.g_term));
	assign b_pix = clamp_shift(y_ext + SUM_W'(cur_q.b_term));

	always_comb begin
		if (cur_q.grey) begin
			pix_data = {3{cur_q.pix[idx_q]}};
		end else begin
			pix_data = {b_pix, g_pix, r_pix};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (done) begin
				cur_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (emit) begin
				idx_q <= idx_q + 1'b1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (emit) begin
			m_data_q <= pix_data;
			m_user_q <= last_pix;
			m_last_q <= last_pix && cur_q.fend;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	`YCV_ASSERT_IMPL(a_frame_implies_item, clk, arst_n, m_valid_q && m_last_q, m_user_q)
	`YCV_ASSERT_NEXT(a_pop_loads, clk, arst_n, pop, cur_valid_q && idx_q == '0)
	`YCV_ASSERT_IMPL(a_colour_idx, clk, arst_n, cur_valid_q && !cur_q.grey, idx_q <= LAST_IDX_COLOUR)

endmodule
